/* sv/slt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Request codes, status codes, back-end states and the request record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RD_MAX      = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
	localparam int CW          = $clog2(CAPACITY + 1);
	localparam int IW          = $clog2(CAPACITY);
	localparam int Q_DEPTH     = 2;
	localparam int QAW         = $clog2(Q_DEPTH);
	localparam int QCW         = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_MODIFY = 3'd2,
		OP_READ   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_READ
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic signed [31:0] new_value;
	} cmd_t;

endpackage

/* sv/slt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_front: request intake
// Registers each incoming request, drops unused opcodes and hands legal
// requests to the queue.
// ----------------------------------------------------------------------------
module slt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  new_value,
	output logic                push_valid,
	input  logic                push_ready,
	output slt_pkg::cmd_t       push_cmd
);
	import slt_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	logic accept;
	logic legal;

	assign in_stall   = vld_s1 && !push_ready;
	assign accept     = in_valid && !in_stall;
	assign legal      = (opcode <= OP_CLEAR);
	assign push_valid = vld_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			if (vld_s1 && push_ready) begin
				vld_s1 <= 1'b0;
			end
			if (accept && legal) begin
				vld_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && legal) begin
			cmd_s1.op        <= op_t'(opcode);
			cmd_s1.value     <= value;
			cmd_s1.new_value <= new_value;
		end
	end

endmodule

/* sv/slt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_queue: request queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module slt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  slt_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output slt_pkg::cmd_t pop_cmd
);
	import slt_pkg::*;

	cmd_t           mem_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != QCW'(Q_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* sv/slt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_back: table cells and executor
// Row of value cells with per-cell compare. Match step tests the request
// against all cells into registered masks; update step shifts, overwrites or
// clears the row, posts the result; read-out: one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
module slt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop,
	input  slt_pkg::cmd_t       pop_cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output slt_pkg::status_t    status,
	output logic signed [31:0]  element,
	output logic                last
);
	import slt_pkg::*;

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic signed [31:0]   entries_q [CAPACITY];
	logic signed [31:0]   ent_d     [CAPACITY];
	logic                 ent_we;
	logic [CW-1:0]        count_q, count_d;
	logic [IW-1:0]        idx_q, idx_d;
	logic [CAPACITY-1:0]  bef_ins_q, bef_eq_q;
	logic [CAPACITY-1:0]  bef_ins_c, bef_eq_c;
	logic                 out_valid_q;
	status_t              status_q;
	logic signed [31:0]   element_q;
	logic                 last_q;
	logic                 out_free;
	logic                 res_load;
	status_t              res_status;
	logic signed [31:0]   res_element;
	logic                 res_last;
	logic [CW-1:0]        rd_n;
	logic                 rd_last;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == S_IDLE) && pop_valid;

	assign rd_n    = (count_q > CW'(RD_MAX)) ? CW'(RD_MAX) : count_q;
	assign rd_last = (CW'(idx_q) + CW'(1)) == rd_n;

	// Match masks: bit i set while no hit has been seen in cells 0..i.
	always_comb begin
		logic run_ins;
		logic run_eq;
		logic live;
		logic hit_ins;
		logic hit_eq;
		run_ins = 1'b1;
		run_eq  = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			live    = (CW'(i) < count_q);
			hit_ins = live ? !(entries_q[i] < pop_cmd.value) : 1'b1;
			hit_eq  = live && (entries_q[i] == pop_cmd.value);
			run_ins = run_ins && !hit_ins;
			run_eq  = run_eq && !hit_eq;
			bef_ins_c[i] = run_ins;
			bef_eq_c[i]  = run_eq;
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		ent_we      = 1'b0;
		res_load    = 1'b0;
		res_status  = ST_OK;
		res_element = '0;
		res_last    = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			ent_d[i] = entries_q[i];
		end

		unique case (state_q)
			S_IDLE: begin
				if (pop_valid) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (out_free) begin
					state_d  = S_IDLE;
					res_load = 1'b1;
					unique case (cmd_q.op)
						OP_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								res_status = ST_FULL;
							end else begin
								ent_we  = 1'b1;
								count_d = count_q + 1'b1;
								ent_d[0] = bef_ins_q[0] ? entries_q[0] : cmd_q.value;
								for (int i = 1; i < CAPACITY; i++) begin
									if (!bef_ins_q[i]) begin
										ent_d[i] = bef_ins_q[i-1] ? cmd_q.value
										                          : entries_q[i-1];
									end
								end
							end
						end
						OP_REMOVE, OP_MODIFY: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else if (bef_eq_q[CAPACITY-1]) begin
								res_status = ST_NOT_FOUND;
							end else if (cmd_q.op == OP_REMOVE) begin
								ent_we  = 1'b1;
								count_d = count_q - 1'b1;
								for (int i = 0; i < CAPACITY - 1; i++) begin
									if (!bef_eq_q[i]) begin
										ent_d[i] = entries_q[i+1];
									end
								end
							end else begin
								ent_we = 1'b1;
								ent_d[0] = bef_eq_q[0] ? entries_q[0] : cmd_q.new_value;
								for (int i = 1; i < CAPACITY; i++) begin
									if (bef_eq_q[i-1] && !bef_eq_q[i]) begin
										ent_d[i] = cmd_q.new_value;
									end
								end
							end
						end
						OP_CLEAR: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								count_d = '0;
							end
						end
						OP_READ: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								res_load = 1'b0;
								idx_d    = '0;
								state_d  = S_READ;
							end
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					res_load    = 1'b1;
					res_element = entries_q[idx_q];
					res_last    = rd_last;
					idx_d       = idx_q + 1'b1;
					if (rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= pop_cmd;
			bef_ins_q <= bef_ins_c;
			bef_eq_q  <= bef_eq_c;
		end
		if (ent_we) begin
			for (int i = 0; i < CAPACITY; i++) begin
				entries_q[i] <= ent_d[i];
			end
		end
		if (res_load) begin
			status_q  <= res_status;
			element_q <= res_element;
			last_q    <= res_last;
		end
	end

endmodule

/* sv/sorted_list_table.sv */
`timescale 1ns / 1ps
// Path: a request passes the intake register, the queue entry, the registered
// match masks and the update step before it reaches the result register.
// The back end takes no new request until its update step is done; read-out
// emits one entry per cycle unless out_stall holds it, up to MAX_RESULTS.
// Reset: arst_n clears the count, queue and control; table cells are not
// cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_list_table: ordered value table
// Front end takes requests, a short queue decouples it from the back end,
// which keeps the sorted cell row and produces status and read-out results.
// ----------------------------------------------------------------------------
module sorted_list_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  new_value,
	output logic                out_valid,
	input  logic                out_stall,
	output slt_pkg::status_t    status,
	output logic signed [31:0]  element,
	output logic                last
);
	import slt_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	cmd_t pop_cmd;

	slt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.value      (value),
		.new_value  (new_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	slt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.element   (element),
		.last      (last)
	);

endmodule

/* sv/slt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker: port-level checks for the sorted list table
// Checks result hold behavior, error results, read-out sequencing and intake stalls.
// ----------------------------------------------------------------------------
module slt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  slt_pkg::status_t    status,
	input  logic signed [31:0]  element,
	input  logic                last
);
	import slt_pkg::*;

	// Held result must not change while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element)
		&& $stable(status) && $stable(last))
		else $error("result changed while stalled");

	// Error statuses always end the request and carry no element.
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && element == 32'sd0)
		else $error("error result not final or has element");

	// Read-out streams without gaps once the sink takes a non-final entry.
	a_read_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_stall |=> out_valid)
		else $error("gap in read-out stream");

	// An idle intake never pushes back.
	a_front_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !in_stall |=> !in_stall)
		else $error("intake stalled with no request");

endmodule

bind sorted_list_table slt_checker u_slt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.element   (element),
	.last      (last)
);
